// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks that vanish from synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds at every rising clock edge outside reset.
`define BDEQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bdeq assertion failed");

// Check that an expression is never true outside reset.
`define BDEQ_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("bdeq forbidden condition seen");

`else

`define BDEQ_ASSERT(lbl, clk, rst_n, prop)
`define BDEQ_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ===== hw/rtl/bdeq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdeq_pkg
// Shared types and constants of the bounded double-ended queue.
// ----------------------------------------------------------------------------
package bdeq_pkg;

  // Request kinds; codes above KIND_QUERY act as a query
  localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [2:0] KIND_POP_BACK   = 3'd3;
  localparam logic [2:0] KIND_QUERY      = 3'd4;

  // Configuration port
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;
  localparam int unsigned CAP_W  = 5;
  localparam logic [CFG_AW-3:0] REG_CAPACITY = 1'b0;
  localparam logic [CAP_W-1:0]  CAP_RESET    = 5'd16;

  localparam int unsigned OCC_W = 5;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic signed [31:0] front_value;
    logic signed [31:0] rear_value;
    logic               is_empty;
    logic               is_full;
    logic [OCC_W-1:0]   occupancy;
  } out_item_t;

  typedef enum logic [1:0] {
    CTRL_IDLE,
    CTRL_READ,
    CTRL_LOAD
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic step;  // apply the incoming request to pointers, count and memory
    logic load;  // move the read words and flags into the output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;  // output register empty or being taken this cycle
  } dp_status_t;

endpackage

// ===== hw/rtl/bdeq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdeq_ctrl
// Sequencer: accept a request, wait for the memory read, load the result.
// ----------------------------------------------------------------------------
module bdeq_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  bdeq_pkg::dp_status_t  sts_i,
  output bdeq_pkg::ctrl_cmd_t   cmd_o
);

  bdeq_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bdeq_pkg::CTRL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      bdeq_pkg::CTRL_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.step = 1'b1;
          state_d    = bdeq_pkg::CTRL_READ;
        end
      end
      bdeq_pkg::CTRL_READ: begin
        state_d = bdeq_pkg::CTRL_LOAD;
      end
      bdeq_pkg::CTRL_LOAD: begin
        // hold until the output register can take the result
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = bdeq_pkg::CTRL_IDLE;
        end
      end
      default: begin
        state_d = bdeq_pkg::CTRL_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/bdeq_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdeq_dpath
// Ring buffer memory, front/back pointers, occupancy and output register.
// ----------------------------------------------------------------------------
module bdeq_dpath #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bdeq_pkg::ctrl_cmd_t            cmd_i,
  output bdeq_pkg::dp_status_t           sts_o,
  input  logic [bdeq_pkg::CAP_W-1:0]     cap_i,
  input  bdeq_pkg::in_item_t             in_item_i,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output bdeq_pkg::out_item_t            out_item_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = (CW > bdeq_pkg::CAP_W) ? CW : bdeq_pkg::CAP_W;
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
  localparam logic [LW-1:0] DEPTH_L  = LW'(DEPTH);

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] idx);
    ring_next = (idx == LAST_IDX) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [PW-1:0] ring_prev(input logic [PW-1:0] idx);
    ring_prev = (idx == '0) ? LAST_IDX : idx - 1'b1;
  endfunction

  logic signed [31:0] mem_q [DEPTH];
  logic signed [31:0] rd_front_q, rd_rear_q;

  logic [PW-1:0] front_q, front_d, back_q, back_d, wr_idx;
  logic [CW-1:0] count_q, count_d;
  logic          ok_q, ok_d, wr_en;

  logic [LW-1:0] limit, cap_ext, count_ext, count_next_ext;
  logic          full_now, empty_now;

  logic                out_valid_q;
  bdeq_pkg::out_item_t out_item_q;

  // Capacity saturates at the ring depth
  assign cap_ext   = LW'(cap_i);
  assign limit     = (cap_ext > DEPTH_L) ? DEPTH_L : cap_ext;
  assign count_ext = LW'(count_q);
  assign full_now  = (count_ext >= limit);
  assign empty_now = (count_q == '0);

  always_comb begin
    front_d = front_q;
    back_d  = back_q;
    count_d = count_q;
    ok_d    = 1'b1;
    wr_en   = 1'b0;
    wr_idx  = back_q;
    case (in_item_i.kind)
      bdeq_pkg::KIND_PUSH_FRONT: begin
        if (full_now) begin
          ok_d = 1'b0;
        end else begin
          front_d = ring_prev(front_q);
          wr_idx  = ring_prev(front_q);
          wr_en   = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      bdeq_pkg::KIND_PUSH_BACK: begin
        if (full_now) begin
          ok_d = 1'b0;
        end else begin
          wr_idx  = back_q;
          wr_en   = 1'b1;
          back_d  = ring_next(back_q);
          count_d = count_q + 1'b1;
        end
      end
      bdeq_pkg::KIND_POP_FRONT: begin
        if (empty_now) begin
          ok_d = 1'b0;
        end else begin
          front_d = ring_next(front_q);
          count_d = count_q - 1'b1;
        end
      end
      bdeq_pkg::KIND_POP_BACK: begin
        if (empty_now) begin
          ok_d = 1'b0;
        end else begin
          back_d  = ring_prev(back_q);
          count_d = count_q - 1'b1;
        end
      end
      default: begin
        // query and unused codes leave the ring alone
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      back_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.step) begin
      front_q <= front_d;
      back_q  <= back_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      ok_q <= ok_d;
    end
  end

  // Ring storage: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.step && wr_en) begin
      mem_q[wr_idx] <= in_item_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_front_q <= mem_q[front_q];
    rd_rear_q  <= mem_q[ring_prev(back_q)];
  end

  // Output register
  assign count_next_ext = LW'(count_q);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_item_q.accepted    <= ok_q;
      out_item_q.front_value <= empty_now ? '1 : rd_front_q;
      out_item_q.rear_value  <= empty_now ? '1 : rd_rear_q;
      out_item_q.is_empty    <= empty_now;
      out_item_q.is_full     <= (count_next_ext >= limit);
      out_item_q.occupancy   <= bdeq_pkg::OCC_W'(count_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== hw/rtl/bounded_double_ended_queue_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_core
// Ring-buffer deque of signed 32-bit words with an APB capacity register.
// ----------------------------------------------------------------------------
// Each input item is one request (push front, push back, pop front, pop back,
// or query; unused kind codes act as a query) and yields exactly one result
// item carrying the accepted flag plus the front and rear words (all ones
// when empty), the empty and full flags and the occupancy after the request.
// A push into a full queue or a pop from an empty one is refused and changes
// nothing. The block works on one item at a time: the accept edge moves the
// pointers and writes the ring memory, the memory then does a registered read
// of the front and rear slots, and the result is loaded into the output
// register once the output side no longer holds an earlier stalled result.
// The next item is accepted only once the result is loaded. The capacity
// register (byte address 0, reset 16) bounds the occupancy; values above
// DEPTH saturate to DEPTH, zero refuses every push. Lowering it below the
// current occupancy keeps the entries. Write it only while no item is in
// flight. Ring storage needs no clearing pass: only slots that hold
// entries are ever reported.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bounded_double_ended_queue_core #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  bdeq_pkg::in_item_t                 in_item_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output bdeq_pkg::out_item_t                out_item_o,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bdeq_pkg::CFG_AW-1:0]        paddr,
  input  logic [bdeq_pkg::CFG_DW-1:0]        pwdata,
  output logic [bdeq_pkg::CFG_DW-1:0]        prdata,
  output logic                               pready
);

  bdeq_pkg::ctrl_cmd_t  cmd;
  bdeq_pkg::dp_status_t sts;

  logic [bdeq_pkg::CAP_W-1:0] cap_q;
  logic                       cap_sel;

  // Decode the capacity register; the low two address bits are ignored
  assign cap_sel = (paddr[bdeq_pkg::CFG_AW-1:2] == bdeq_pkg::REG_CAPACITY);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= bdeq_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && pready && cap_sel) begin
      cap_q <= pwdata[bdeq_pkg::CAP_W-1:0];
    end
  end

  // Read back the stored register, zero elsewhere
  assign prdata = cap_sel ? bdeq_pkg::CFG_DW'(cap_q) : '0;

  // Sequencer: one item in flight at a time
  bdeq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Ring storage, pointers and the result register
  bdeq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cap_i       (cap_q),
    .in_item_i   (in_item_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

  // An accepted item blocks the next one until its result is loaded
  `BDEQ_ASSERT(a_one_in_flight, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o)
  // Never load a new result over one that is held and stalled
  `BDEQ_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, cmd.load && !sts.out_free)
  // A result shows up only after the sequencer loaded it
  `BDEQ_ASSERT(a_rise_after_load, clk_i, rst_ni, $rose(out_valid_o) |-> $past(cmd.load))
  // An empty queue reports all ones for both ends
  `BDEQ_ASSERT(a_empty_words, clk_i, rst_ni, (out_valid_o && out_item_o.is_empty) |-> ((out_item_o.front_value == '1) && (out_item_o.rear_value == '1)))

endmodule

// ===== dv/bdeq_scoreboard.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdeq_scoreboard
// Watches both item channels and the capacity port of the deque, predicts
// each result from a private ring-buffer copy and compares it field by field.
// ----------------------------------------------------------------------------
module bdeq_scoreboard
  import bdeq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  in_item_t          in_item_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  out_item_t         out_item_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  input  logic              pready,
  output int unsigned       pending_o,
  output int unsigned       error_count_o
);

  logic signed [31:0] ring [DEPTH];
  int unsigned        head_slot;
  int unsigned        tail_slot;  // one past the rear entry
  int unsigned        held;
  logic [CAP_W-1:0]   capacity;
  out_item_t          snapshots_q [$];
  int unsigned        mismatches = 0;

  assign error_count_o = mismatches;

  function automatic int unsigned slot_after(int unsigned i);
    return (i + 1 >= DEPTH) ? 0 : i + 1;
  endfunction

  function automatic int unsigned slot_before(int unsigned i);
    return (i == 0) ? DEPTH - 1 : i - 1;
  endfunction

  // Apply one request to the ring copy and return the view after it.
  function automatic out_item_t apply_request(in_item_t req);
    int unsigned bound;
    logic        full;
    out_item_t   view;
    bound = (capacity > DEPTH) ? DEPTH : capacity;
    full  = (held >= bound);
    view  = '0;
    view.accepted = 1'b1;
    case (req.kind)
      KIND_PUSH_FRONT: begin
        if (full) begin
          view.accepted = 1'b0;
        end else begin
          head_slot = slot_before(head_slot);
          ring[head_slot] = req.value;
          held++;
        end
      end
      KIND_PUSH_BACK: begin
        if (full) begin
          view.accepted = 1'b0;
        end else begin
          ring[tail_slot] = req.value;
          tail_slot = slot_after(tail_slot);
          held++;
        end
      end
      KIND_POP_FRONT: begin
        if (held == 0) begin
          view.accepted = 1'b0;
        end else begin
          head_slot = slot_after(head_slot);
          held--;
        end
      end
      KIND_POP_BACK: begin
        if (held == 0) begin
          view.accepted = 1'b0;
        end else begin
          tail_slot = slot_before(tail_slot);
          held--;
        end
      end
      default: ;  // query and unused codes change nothing
    endcase
    view.front_value = (held != 0) ? ring[head_slot] : '1;
    view.rear_value  = (held != 0) ? ring[slot_before(tail_slot)] : '1;
    view.is_empty    = (held == 0);
    view.is_full     = (held >= bound);
    view.occupancy   = OCC_W'(held);
    return view;
  endfunction

  task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      head_slot = 0;
      tail_slot = 0;
      held      = 0;
      capacity  = CAP_RESET;
      snapshots_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (snapshots_q.size() == 0) begin
          mismatches++;
          $display("%0t ns: result with no prediction waiting, got %h", $time, out_item_i);
        end else begin
          want = snapshots_q.pop_front();
          report_field("accepted", want.accepted, out_item_i.accepted);
          report_field("front_value", want.front_value, out_item_i.front_value);
          report_field("rear_value", want.rear_value, out_item_i.rear_value);
          report_field("is_empty", want.is_empty, out_item_i.is_empty);
          report_field("is_full", want.is_full, out_item_i.is_full);
          report_field("occupancy", want.occupancy, out_item_i.occupancy);
        end
      end
      if (psel && penable && pwrite && pready && paddr[CFG_AW-1:2] == REG_CAPACITY) begin
        capacity = pwdata[CAP_W-1:0];
      end
      if (in_valid_i && !in_stall_i) begin
        snapshots_q.push_back(apply_request(in_item_i));
      end
      pending_o <= snapshots_q.size();
    end
  end

endmodule

// ===== dv/tb_bounded_double_ended_queue_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_double_ended_queue_core
// Drives requests and capacity writes into the deque core and gives the
// verdict; the scoreboard beside the core predicts and checks every result.
// ----------------------------------------------------------------------------
// A short directed run covers refused pushes and pops, the word extremes,
// the unused kind codes and capacity changes (zero, lowered below the
// occupancy). Random phases then run biased push and pop bursts under
// several capacities, with random sender gaps and receiver stalls, two long
// receiver hold-offs, and a final stretch with no random gaps or stalls.
// ----------------------------------------------------------------------------
module tb_bounded_double_ended_queue_core;
  import bdeq_pkg::*;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned PHASES       = 12;
  localparam int unsigned PHASE_ITEMS  = 138;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // Capacity per random phase: saturation, zero and one are all visited.
  localparam logic [CAP_W-1:0] PHASE_CAPACITY [PHASES] = '{
    5'd16, 5'd31, 5'd0, 5'd1, 5'd17, 5'd4, 5'd16, 5'd2, 5'd9, 5'd24, 5'd13, 5'd16
  };

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  in_item_t          in_item_i;
  logic              out_valid_o;
  logic              out_stall_i;
  out_item_t         out_item_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  int unsigned results_pending;
  int unsigned error_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic        hold_req;
  int unsigned cycle_count = 0;

  bounded_double_ended_queue_core #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  bdeq_scoreboard #(
    .DEPTH(DEPTH)
  ) scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_i   (out_item_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .pending_o    (results_pending),
    .error_count_o(error_count)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake or a missing result ends here.
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("bounded_double_ended_queue_core test failed");
    $finish;
  end

  // Result side: random stalls, or a long hold-off counted here once the
  // stimulus asks for one, so the core backs up and stalls its input.
  initial begin : result_sink
    int unsigned hold_left;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Offer one item and hold it until the core takes it; then maybe leave a
  // gap. Valid stays high into the next item when no gap is drawn.
  task automatic issue_request(input logic [2:0] kind, input logic signed [31:0] word);
    in_valid_i      <= 1'b1;
    in_item_i.kind  <= kind;
    in_item_i.value <= word;
    do @(posedge clk_i); while (in_stall_o);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Drain every outstanding result, then write the capacity register with
  // an APB setup and access cycle.
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (results_pending != 0);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_CAPACITY, 2'b00};
    pwdata  <= CFG_DW'(cap);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned         run_left;
    logic                grow;
    int unsigned         roll;
    logic [2:0]          kind;
    logic signed [31:0]  word;

    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_item_i      = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    hold_req       = 1'b0;
    send_idle_pct  = 34;
    recv_stall_pct = 60;
    run_left       = 0;
    grow           = 1'b1;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty queue, refused pops, word extremes at both ends.
    issue_request(KIND_QUERY, 32'sd0);
    issue_request(KIND_POP_FRONT, $urandom);
    issue_request(KIND_POP_BACK, $urandom);
    issue_request(KIND_PUSH_BACK, 32'sh7FFF_FFFF);
    issue_request(KIND_PUSH_FRONT, 32'sh8000_0000);
    issue_request(KIND_PUSH_BACK, -32'sd1);  // looks like the empty marker
    issue_request(KIND_PUSH_FRONT, 32'sd0);
    // Unused kind codes act as a query.
    issue_request(KIND_QUERY + 3'd1, $urandom);
    issue_request(KIND_QUERY + 3'd2, $urandom);
    issue_request(KIND_QUERY + 3'd3, $urandom);
    issue_request(KIND_POP_FRONT, $urandom);
    issue_request(KIND_POP_BACK, $urandom);
    // Two entries left: capacity two makes the queue full.
    write_capacity(5'd2);
    issue_request(KIND_PUSH_BACK, $urandom);
    issue_request(KIND_QUERY, $urandom);
    // Capacity below the occupancy: entries stay, pushes are refused.
    write_capacity(5'd1);
    issue_request(KIND_PUSH_FRONT, $urandom);
    issue_request(KIND_POP_BACK, $urandom);
    issue_request(KIND_POP_FRONT, $urandom);
    issue_request(KIND_PUSH_FRONT, 32'sh5A5A_A5A5);
    // Capacity zero: reads as full even when empty, every push refused.
    write_capacity(5'd0);
    issue_request(KIND_PUSH_BACK, $urandom);
    issue_request(KIND_QUERY, $urandom);
    issue_request(KIND_POP_FRONT, $urandom);
    issue_request(KIND_PUSH_FRONT, $urandom);
    issue_request(KIND_QUERY, $urandom);

    // Random phases: bursts that lean toward growing or shrinking the queue
    // so it reaches full and empty and wraps the ring many times.
    for (int phase = 0; phase < PHASES; phase++) begin
      write_capacity(PHASE_CAPACITY[phase]);
      if (phase < 4) begin
        send_idle_pct  = 34;
        recv_stall_pct = 60;
      end else if (phase < 8) begin
        send_idle_pct  = 60;
        recv_stall_pct = 34;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      if (phase == 5 || phase == 9) begin
        hold_req = 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (run_left == 0) begin
          grow     = 1'($urandom_range(1));
          run_left = $urandom_range(3, 40);
        end
        run_left--;
        roll = $urandom_range(99);
        if (roll < 6) begin
          kind = KIND_QUERY + 3'($urandom_range(3));
        end else if ((roll < 76) == grow) begin
          kind = $urandom_range(1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
        end else begin
          kind = $urandom_range(1) ? KIND_POP_BACK : KIND_POP_FRONT;
        end
        case ($urandom_range(19))
          0:       word = 32'sh7FFF_FFFF;
          1:       word = 32'sh8000_0000;
          2:       word = -32'sd1;
          3:       word = 32'sd0;
          default: word = $urandom;
        endcase
        issue_request(kind, word);
      end
    end

    // Drop valid, wait for the last result, let the core settle.
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (results_pending != 0);
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("bounded_double_ended_queue_core test passed");
    end else begin
      $display("bounded_double_ended_queue_core test failed");
    end
    $finish;
  end

endmodule
